### hdl/dcc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcc_pkg
// Shared constants, types and codes of the DCC packet decoder.
// ----------------------------------------------------------------------------
package dcc_pkg;

    localparam int BUF_DEPTH = 10;                     // packet store entries
    localparam int ADDR_W    = $clog2(BUF_DEPTH);      // store address
    localparam int CNT_W     = $clog2(BUF_DEPTH + 1);  // byte count 0..BUF_DEPTH
    localparam int IDX_W     = 4;                      // byte_index field
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 8;

    localparam logic [6:0] PREAMBLE_SAT     = 7'd100;
    localparam logic [6:0] PREAMBLE_MIN_RST = 7'd20;
    localparam logic [7:0] SHORT_LIMIT_RST  = 8'd43;    // 87/2
    localparam int         MIN_PACKET       = 3;

    typedef logic [7:0]           t_byte;
    typedef logic [ADDR_W-1:0]    t_addr;
    typedef logic [CNT_W-1:0]     t_cnt;
    typedef logic [IDX_W-1:0]     t_idx;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    typedef logic [CFG_DAT_W-1:0] t_cfg_dat;

    // register indexes of the configuration port
    localparam t_cfg_idx CFG_ENABLE       = 2'd0;
    localparam t_cfg_idx CFG_SHORT_LIMIT  = 2'd1;
    localparam t_cfg_idx CFG_PREAMBLE_MIN = 2'd2;

    // request from the decoder to the emitter
    typedef struct packed {
        logic start;
        t_cnt count;
    } t_emit_cmd;

    // store write port
    typedef struct packed {
        logic  we;
        t_addr addr;
        t_byte data;
    } t_store_wr;

    // store read port
    typedef struct packed {
        logic  re;
        t_addr addr;
    } t_store_rd;

endpackage

### hdl/dcc_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcc_ifs
// Valid/ready channels: edge events, packet bytes and register writes.
// ----------------------------------------------------------------------------
interface dcc_edge_if;
    import dcc_pkg::*;
    logic       valid;
    logic       ready;
    logic [7:0] interval;
    logic       overflow;
    modport source (output valid, interval, overflow, input ready);
    modport sink   (input valid, interval, overflow, output ready);
endinterface

interface dcc_byte_if;
    import dcc_pkg::*;
    logic  valid;
    logic  ready;
    t_byte packet_byte;
    t_idx  byte_index;
    logic  last_byte;
    modport source (output valid, packet_byte, byte_index, last_byte, input ready);
    modport sink   (input valid, packet_byte, byte_index, last_byte, output ready);
endinterface

interface dcc_cfg_if;
    import dcc_pkg::*;
    logic     valid;
    logic     ready;
    t_cfg_idx index;
    t_cfg_dat data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### hdl/dcc_packet_decoder_top.sv
`timescale 1ns / 1ps
// Flow: an edge beat is decoded in the cycle it is accepted; a closing end
//   bit starts the byte emitter; bytes leave via the registered store read.
// Throughput: one edge beat per cycle while no packet is being sent; a packet
//   holds off edges while its bytes are read out (one store read per byte),
//   and while the byte sink stalls. An offered register write also holds edges.
// Reset (i_rst_n, synchronous): decoder stopped, counters cleared, registers
//   at their defaults; the packet store is not cleared.
// ----------------------------------------------------------------------------
// dcc_packet_decoder_top
// DCC track signal decoder: edge intervals to half-bits, preamble search,
// bit/byte assembly with XOR check, and emission of checked packets.
// ----------------------------------------------------------------------------
module dcc_packet_decoder_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dcc_edge_if.sink   i_edge,
    dcc_cfg_if.sink    i_cfg,
    dcc_byte_if.source o_pkt
);
    import dcc_pkg::*;

    // decoder phase; the first edge after enable only synchronises
    typedef enum logic [2:0] {
        PH_OFF      = 3'd0,
        PH_FIRST    = 3'd1,
        PH_PREAMBLE = 3'd2,
        PH_START    = 3'd3,   // second half of the start bit
        PH_H1       = 3'd4,   // first half of a data, separator or end bit
        PH_H2       = 3'd5,   // second half of a data bit
        PH_STOP     = 3'd6    // second half of a separator or end bit
    } t_phase;

    // configuration registers
    logic       r_enable;
    logic [7:0] r_short_limit;
    logic [6:0] r_preamble_min;

    // decoder state
    t_phase     r_phase,     n_phase;
    logic [6:0] r_pre_cnt,   n_pre_cnt;
    t_cnt       r_byte_cnt,  n_byte_cnt;
    logic [3:0] r_bit_cnt,   n_bit_cnt;
    t_byte      r_shift,     n_shift;
    logic       r_first,     n_first;
    t_byte      r_xor,       n_xor;

    logic      w_accept;
    logic      w_cfg_wr;
    logic      w_hb;
    logic      w_emit_busy;
    t_emit_cmd w_cmd;
    t_store_wr w_wr;
    t_store_rd w_rd;
    t_byte     w_rd_data;

    // edges are held off while a packet is being read out, and while a
    // register write is offered so that no edge beat is taken and dropped
    assign i_edge.ready = !w_emit_busy && !i_cfg.valid;
    assign i_cfg.ready  = 1'b1;
    assign w_accept     = i_edge.valid && i_edge.ready;
    assign w_cfg_wr     = i_cfg.valid && i_cfg.ready;

    // half-bit: a one when short and no timer overflow
    assign w_hb = !i_edge.overflow && (i_edge.interval < r_short_limit);

    always_comb begin
        n_phase    = r_phase;
        n_pre_cnt  = r_pre_cnt;
        n_byte_cnt = r_byte_cnt;
        n_bit_cnt  = r_bit_cnt;
        n_shift    = r_shift;
        n_first    = r_first;
        n_xor      = r_xor;
        w_cmd      = '{start: 1'b0, count: r_byte_cnt};
        w_wr       = '{we: 1'b0, addr: r_byte_cnt[ADDR_W-1:0], data: r_shift};

        if (w_cfg_wr) begin
            if (i_cfg.index == CFG_ENABLE) begin
                if (i_cfg.data[0]) begin
                    n_phase    = PH_FIRST;
                    n_pre_cnt  = '0;
                    n_byte_cnt = '0;
                end else begin
                    n_phase = PH_OFF;
                end
            end
        end else if (w_accept) begin
            case (r_phase)
                PH_FIRST: begin
                    n_phase   = PH_PREAMBLE;
                    n_pre_cnt = '0;
                end
                PH_PREAMBLE: begin
                    if (w_hb) begin
                        if (r_pre_cnt < PREAMBLE_SAT) begin
                            n_pre_cnt = r_pre_cnt + 7'd1;
                        end
                    end else if (r_pre_cnt >= r_preamble_min) begin
                        n_phase = PH_START;
                    end else begin
                        n_pre_cnt = '0;
                    end
                end
                PH_START: begin
                    if (w_hb) begin
                        n_phase    = PH_PREAMBLE;
                        n_pre_cnt  = '0;
                        n_byte_cnt = '0;
                        n_xor      = '0;
                    end else begin
                        n_phase    = PH_H1;
                        n_byte_cnt = '0;
                        n_bit_cnt  = '0;
                        n_xor      = '0;
                    end
                end
                PH_H1: begin
                    n_first = w_hb;
                    if (r_bit_cnt < 4'd8) begin
                        n_phase = PH_H2;
                    end else begin
                        // byte complete; past the store depth only the check sees it
                        if (r_byte_cnt < t_cnt'(BUF_DEPTH)) begin
                            w_wr.we    = 1'b1;
                            n_byte_cnt = r_byte_cnt + t_cnt'(1);
                        end
                        n_xor   = r_xor ^ r_shift;
                        n_phase = PH_STOP;
                    end
                end
                PH_H2: begin
                    if (w_hb != r_first) begin
                        n_phase    = PH_PREAMBLE;
                        n_pre_cnt  = '0;
                        n_byte_cnt = '0;
                        n_xor      = '0;
                    end else begin
                        n_shift   = {r_shift[6:0], w_hb};
                        n_bit_cnt = r_bit_cnt + 4'd1;
                        n_phase   = PH_H1;
                    end
                end
                PH_STOP: begin
                    if (w_hb != r_first || w_hb) begin
                        // mismatch or end bit: back to preamble search
                        if (w_hb == r_first && r_byte_cnt >= t_cnt'(MIN_PACKET)
                            && r_xor == '0) begin
                            w_cmd.start = 1'b1;
                        end
                        n_phase    = PH_PREAMBLE;
                        n_pre_cnt  = '0;
                        n_byte_cnt = '0;
                        n_xor      = '0;
                    end else begin
                        n_phase   = PH_H1;
                        n_bit_cnt = '0;
                    end
                end
                default: begin
                    // stopped: edges are ignored
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable       <= 1'b0;
            r_short_limit  <= SHORT_LIMIT_RST;
            r_preamble_min <= PREAMBLE_MIN_RST;
            r_phase        <= PH_OFF;
            r_pre_cnt      <= '0;
            r_byte_cnt     <= '0;
            r_bit_cnt      <= '0;
            r_shift        <= '0;
            r_first        <= 1'b0;
            r_xor          <= '0;
        end else begin
            if (w_cfg_wr) begin
                case (i_cfg.index)
                    CFG_ENABLE:       r_enable       <= i_cfg.data[0];
                    CFG_SHORT_LIMIT:  r_short_limit  <= i_cfg.data;
                    CFG_PREAMBLE_MIN: r_preamble_min <= i_cfg.data[6:0];
                    default: begin
                    end
                endcase
            end
            r_phase    <= r_enable || w_cfg_wr ? n_phase : PH_OFF;
            r_pre_cnt  <= n_pre_cnt;
            r_byte_cnt <= n_byte_cnt;
            r_bit_cnt  <= n_bit_cnt;
            r_shift    <= n_shift;
            r_first    <= n_first;
            r_xor      <= n_xor;
        end
    end

    dcc_store u_store (
        .i_clk     (i_clk),
        .i_wr      (w_wr),
        .i_rd      (w_rd),
        .o_rd_data (w_rd_data)
    );

    dcc_emit u_emit (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .o_busy    (w_emit_busy),
        .o_rd      (w_rd),
        .i_rd_data (w_rd_data),
        .o_pkt     (o_pkt)
    );

endmodule

### hdl/dcc_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcc_store
// Packet byte store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module dcc_store (
    input  logic              i_clk,
    input  dcc_pkg::t_store_wr i_wr,
    input  dcc_pkg::t_store_rd i_rd,
    output dcc_pkg::t_byte    o_rd_data
);
    import dcc_pkg::*;

    t_byte r_mem [BUF_DEPTH];
    t_byte r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        // data holds while no read is issued
        if (i_rd.re) begin
            r_rd_data <= r_mem[i_rd.addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### hdl/dcc_emit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcc_emit
// Walks the store from entry 0 and sends each byte as one beat.
// ----------------------------------------------------------------------------
module dcc_emit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  dcc_pkg::t_emit_cmd i_cmd,
    output logic               o_busy,
    output dcc_pkg::t_store_rd o_rd,
    input  dcc_pkg::t_byte     i_rd_data,
    dcc_byte_if.source         o_pkt
);
    import dcc_pkg::*;

    logic r_busy;
    logic r_valid;
    t_cnt r_idx;
    t_cnt r_count;
    t_idx r_out_idx;
    logic r_out_last;
    logic w_issue;
    logic w_last;

    // the store read register is the output data register: read only when
    // the slot is empty or being taken
    assign w_issue = r_busy && (!r_valid || o_pkt.ready);
    assign w_last  = ((r_idx + t_cnt'(1)) == r_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
            r_idx   <= '0;
            r_count <= '0;
        end else begin
            if (i_cmd.start) begin
                r_busy  <= 1'b1;
                r_idx   <= '0;
                r_count <= i_cmd.count;
            end else if (w_issue) begin
                r_idx <= r_idx + t_cnt'(1);
                if (w_last) begin
                    r_busy <= 1'b0;
                end
            end
            if (w_issue) begin
                r_valid <= 1'b1;
            end else if (o_pkt.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_out_idx  <= t_idx'(r_idx);
            r_out_last <= w_last;
        end
    end

    assign o_rd.re   = w_issue;
    assign o_rd.addr = r_idx[ADDR_W-1:0];

    assign o_busy            = r_busy;
    assign o_pkt.valid       = r_valid;
    assign o_pkt.packet_byte = i_rd_data;
    assign o_pkt.byte_index  = r_out_idx;
    assign o_pkt.last_byte   = r_out_last;

endmodule
